FILE: hw/rtl/bsi_pkg.sv
`default_nettype none
package bsi_pkg;

  localparam int FracBits = 16;
  localparam int NumRegs  = 6;

  // half a unit, the corner offset of the unit square
  localparam logic signed [31:0] Half = 32'sd1 <<< (FracBits - 1);

  localparam logic [2:0] RegXx = 3'd0;
  localparam logic [2:0] RegXy = 3'd1;
  localparam logic [2:0] RegYx = 3'd2;
  localparam logic [2:0] RegYy = 3'd3;
  localparam logic [2:0] RegTx = 3'd4;
  localparam logic [2:0] RegTy = 3'd5;

  typedef struct packed {
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
  } bsi_in_t;

  typedef struct packed {
    logic               hit;
    logic [1:0]         hit_edge;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } bsi_out_t;

  // saturate a 34-bit signed value to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] mx;
    logic signed [33:0] mn;
    mx = 34'sh0_7FFF_FFFF;
    mn = -34'sh0_8000_0000;
    if (v > mx) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < mn) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // difference saturated to +-(2^31-1)
  function automatic logic signed [31:0] sat_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sh0_7FFF_FFFF) begin
      sat_diff = 32'sh7FFF_FFFF;
    end else if (d < -33'sh0_7FFF_FFFF) begin
      sat_diff = -32'sh7FFF_FFFF;
    end else begin
      sat_diff = d[31:0];
    end
  endfunction

  // shift right by FracBits truncating toward zero
  function automatic logic signed [63:0] tr_shift(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = m >> FracBits;
    tr_shift = v[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/box_segment_intersection.sv
`default_nettype none
// box / line segment intersection, q16.16
// input channel: in_valid_i / in_stall_o carry one word with the segment
// offset, start and end. output channel: out_valid_o / out_stall_i carry
// one word: hit flag, first edge hit (0 top, 1 right, 2 bottom, 3 left)
// and the crossing point, all zero on a miss.
// configuration: cfg_we_i, cfg_idx_i, cfg_data_i write the six box
// transform registers; other indexes are ignored. the user must write
// them only while the block is idle; the block itself does not enforce it.
// each word is worked by one shared 32x32 multiplier and one shared
// restoring divider (one quotient bit per cycle) under a sequencer:
// multiply steps for the corners, then per edge multiply steps and a
// compare step; on a hit the divide and multiply steps for the point.
// the block returns to idle before the next accept, and one word is in
// flight at a time.
// the result sits in an output register; a stall on the output holds it
// and a new word is taken only once that result has gone.
// reset (rst_ni low, asynchronous) loads the identity transform and
// empties the block.
module box_segment_intersection
  import bsi_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire bsi_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output bsi_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StCorn = 8'b0000_0010,
    StEdge = 8'b0000_0100,
    StTest = 8'b0000_1000,
    StDiv  = 8'b0001_0000,
    StPt   = 8'b0010_0000,
    StFin  = 8'b0100_0000,
    StOut  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic signed [31:0] reg_q [NumRegs];
  logic signed [31:0] cx_q [4];
  logic signed [31:0] cy_q [4];
  logic signed [31:0] x3_q, y3_q, x4_q, y4_q;
  logic [3:0]         step_q;
  logic [1:0]         edge_q;
  logic signed [63:0] acc_q, den_q, na_q, nb_q;
  logic signed [63:0] prod_q;
  logic [63:0]        rem_q, dvs_q;
  logic [FracBits:0]  quo_q;
  logic [4:0]         dcnt_q;
  bsi_out_t           out_q;

  // current edge endpoints and deltas
  logic [1:0]         en;
  logic signed [31:0] x1, y1, dx1, dy1, dx2, dy2, ex, ey;
  assign en  = edge_q + 2'd1;
  assign x1  = cx_q[edge_q];
  assign y1  = cy_q[edge_q];
  assign dx1 = sat_diff(cx_q[en], x1);
  assign dy1 = sat_diff(cy_q[en], y1);
  assign dx2 = sat_diff(x4_q, x3_q);
  assign dy2 = sat_diff(y4_q, y3_q);
  assign ex  = sat_diff(x1, x3_q);
  assign ey  = sat_diff(y1, y3_q);

  // shared multiplier operand select
  logic signed [31:0] ma, mb;
  logic [1:0]         ci;
  assign ci = step_q[3:2];
  always_comb begin
    ma = '0;
    mb = '0;
    if (state_q == StCorn) begin
      // corner i: step bit 1 picks x/y, bit 0 picks vx or vy term
      ma = (step_q[0] == 1'b0)
           ? ((ci == 2'd0 || ci == 2'd3) ? -Half : Half)
           : ((ci == 2'd0 || ci == 2'd1) ? Half : -Half);
      case (step_q[1:0])
        2'd0:    mb = reg_q[RegXx];
        2'd1:    mb = reg_q[RegYx];
        2'd2:    mb = reg_q[RegXy];
        2'd3:    mb = reg_q[RegYy];
        default: mb = '0;
      endcase
    end else if (state_q == StEdge) begin
      case (step_q[2:0])
        3'd0:    begin ma = dy2; mb = dx1; end
        3'd1:    begin ma = dx2; mb = dy1; end
        3'd2:    begin ma = dx2; mb = ey;  end
        3'd3:    begin ma = dy2; mb = ex;  end
        3'd4:    begin ma = dx1; mb = ey;  end
        3'd5:    begin ma = dy1; mb = ex;  end
        default: begin ma = '0;  mb = '0;  end
      endcase
    end else if (state_q == StPt) begin
      ma = 32'(quo_q);
      mb = step_q[0] ? dy1 : dx1;
    end
  end

  logic signed [63:0] mul;
  assign mul = 64'(ma) * 64'(mb);

  logic signed [63:0] tsh;
  assign tsh = tr_shift(prod_q);

  // hit test
  logic [63:0] mden, mna, mnb;
  logic        ok_a, ok_b;
  assign mden = den_q[63] ? 64'(-den_q) : 64'(den_q);
  assign mna  = na_q[63] ? 64'(-na_q) : 64'(na_q);
  assign mnb  = nb_q[63] ? 64'(-nb_q) : 64'(nb_q);
  assign ok_a = !((na_q != 0) && (na_q[63] != den_q[63])) && (mna <= mden);
  assign ok_b = !((nb_q != 0) && (nb_q[63] != den_q[63])) && (mnb <= mden);

  logic [63:0] rsh;
  assign rsh = {rem_q[62:0], 1'b0};

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StCorn;
      StCorn: if (step_q == 4'd15) state_d = StEdge;
      StEdge: if (step_q == 4'd6) state_d = StTest;
      StTest: begin
        if (den_q != 0 && ok_a && ok_b) begin
          state_d = StDiv;
        end else if (edge_q == 2'd3) begin
          state_d = StFin;
        end else begin
          state_d = StEdge;
        end
      end
      StDiv:  if (dcnt_q == 5'(FracBits)) state_d = StPt;
      StPt:   if (step_q == 4'd3) state_d = StFin;
      StFin:  state_d = StOut;
      StOut:  if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      edge_q  <= '0;
      dcnt_q  <= '0;
      reg_q[RegXx] <= 32'sd1 <<< FracBits;
      reg_q[RegXy] <= '0;
      reg_q[RegYx] <= '0;
      reg_q[RegYy] <= 32'sd1 <<< FracBits;
      reg_q[RegTx] <= '0;
      reg_q[RegTy] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i < 3'(NumRegs)) begin
        reg_q[cfg_idx_i] <= cfg_data_i;
      end
      case (state_q)
        StIdle: begin
          step_q <= '0;
          edge_q <= '0;
        end
        StCorn: step_q <= step_q + 4'd1;
        StEdge: step_q <= (step_q == 4'd6) ? 4'd0 : step_q + 4'd1;
        StTest: begin
          dcnt_q <= '0;
          if (!(den_q != 0 && ok_a && ok_b)) begin
            edge_q <= edge_q + 2'd1;
          end
        end
        StDiv:  dcnt_q <= dcnt_q + 5'd1;
        StPt:   step_q <= step_q + 4'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul;
    case (state_q)
      StIdle: begin
        x3_q <= sat32(34'(in_data_i.start_x) + 34'(in_data_i.offset_x));
        y3_q <= sat32(34'(in_data_i.start_y) + 34'(in_data_i.offset_y));
        x4_q <= sat32(34'(in_data_i.end_x) + 34'(in_data_i.offset_x));
        y4_q <= sat32(34'(in_data_i.end_y) + 34'(in_data_i.offset_y));
        out_q <= '0;
      end
      StCorn: begin
        // product of step s-1 lands at step s; first term of a pair kept
        if (step_q[0] == 1'b1) begin
          acc_q <= prod_q;
        end
        if (step_q[0] == 1'b0 && step_q != 4'd0) begin
          // prod_q holds second term of pair step_q-1
          if (step_q[1] == 1'b0) begin
            // completed pair index step_q-1 has bit1 set: y
            cy_q[ci - 2'd1] <= sat32(34'(reg_q[RegTy]) + 34'(tr_shift(acc_q + prod_q)));
          end else begin
            cx_q[ci] <= sat32(34'(reg_q[RegTx]) + 34'(tr_shift(acc_q + prod_q)));
          end
        end
      end
      StEdge: begin
        case (step_q[2:0])
          3'd1: den_q <= prod_q;
          3'd2: den_q <= den_q - prod_q;
          3'd3: na_q  <= prod_q;
          3'd4: na_q  <= na_q - prod_q;
          3'd5: nb_q  <= prod_q;
          3'd6: nb_q  <= nb_q - prod_q;
          default: ;
        endcase
        if (step_q == 4'd0 && edge_q == 2'd0) begin
          cy_q[3] <= sat32(34'(reg_q[RegTy]) + 34'(tr_shift(acc_q + prod_q)));
        end
      end
      StTest: begin
        // first quotient bit taken here since |na| <= |den|
        dvs_q <= mden;
        if (mna >= mden) begin
          quo_q <= (FracBits+1)'(1);
          rem_q <= mna - mden;
        end else begin
          quo_q <= '0;
          rem_q <= mna;
        end
      end
      StDiv: begin
        if (dcnt_q != 5'(FracBits)) begin
          if (rsh >= dvs_q) begin
            rem_q <= rsh - dvs_q;
            quo_q <= {quo_q[FracBits-1:0], 1'b1};
          end else begin
            rem_q <= rsh;
            quo_q <= {quo_q[FracBits-1:0], 1'b0};
          end
        end
      end
      StPt: begin
        out_q.hit      <= 1'b1;
        out_q.hit_edge <= edge_q;
        if (step_q == 4'd1) begin
          out_q.cross_x <= sat32(34'(x1) + 34'(tsh));
        end
        if (step_q == 4'd2) begin
          out_q.cross_y <= sat32(34'(y1) + 34'(tsh));
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: dv/tb_box_segment_intersection.sv
`default_nettype none
module tb_box_segment_intersection;
  import bsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LimitCycles = 3_000_000;
  localparam int          DrainCycles = 120;
  localparam logic [2:0]  RegBad6     = 3'd6;
  localparam logic [2:0]  RegBad7     = 3'd7;
  localparam logic [31:0] One         = 32'h0001_0000;
  localparam logic [31:0] SMax        = 32'h7FFF_FFFF;
  localparam logic [31:0] SMin        = 32'h8000_0000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bsi_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bsi_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [31:0] cfg_data = '0;

  // shadow of the box transform registers
  longint   box_cfg [NumRegs];
  // crossings expected, oldest first
  bsi_out_t crossing_q [$];
  int       errors = 0;
  int       cycle_cnt = 0;
  // no idling on either side in the last part
  bit       quiet = 1'b0;
  // request for a long output hold-off
  bit       hold_req = 1'b0;

  box_segment_intersection u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // crossing predictor, 64-bit integer arithmetic
  // ---------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // difference clamped symmetric to +-(2^31-1)
  function automatic longint clamp_diff(longint a, longint b);
    longint d;
    d = a - b;
    if (d > 64'sd2147483647) return 64'sd2147483647;
    if (d < -64'sd2147483647) return -64'sd2147483647;
    return d;
  endfunction

  // drop fraction bits, rounding toward zero
  function automatic longint drop_frac(longint v);
    if (v >= 0) return v >>> FracBits;
    return -((-v) >>> FracBits);
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // num/den within [0,1]
  function automatic bit in_span(longint num, longint den);
    if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
    return absl(num) <= absl(den);
  endfunction

  // edge parameter as a fraction, truncating restoring division
  function automatic longint edge_param(longint n, longint d);
    logic [64:0] r;
    logic [64:0] dd;
    longint      q;
    r  = 65'(n);
    dd = 65'(d);
    q  = 0;
    if (r >= dd) begin
      q = 1;
      r = r - dd;
    end
    for (int i = 0; i < FracBits; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= dd) begin
        q = q | 1;
        r = r - dd;
      end
    end
    return q;
  endfunction

  function automatic bsi_out_t predict_crossing(bsi_in_t w);
    longint sgn_x [4] = '{-1, 1, 1, -1};
    longint sgn_y [4] = '{1, 1, -1, -1};
    longint half;
    longint cx [4];
    longint cy [4];
    longint ox, oy, x3, y3, x4, y4;
    longint x1, y1, x2, y2, dx1, dy1, dx2, dy2, ex, ey, den, na, nb, ua;
    bsi_out_t res;
    half = longint'(1) <<< (FracBits - 1);
    ox = w.offset_x;
    oy = w.offset_y;
    x3 = clamp32(longint'(w.start_x) + ox);
    y3 = clamp32(longint'(w.start_y) + oy);
    x4 = clamp32(longint'(w.end_x) + ox);
    y4 = clamp32(longint'(w.end_y) + oy);
    res = '0;
    for (int i = 0; i < 4; i++) begin
      cx[i] = clamp32(box_cfg[RegTx] + drop_frac(sgn_x[i] * half * box_cfg[RegXx]
                                                 + sgn_y[i] * half * box_cfg[RegYx]));
      cy[i] = clamp32(box_cfg[RegTy] + drop_frac(sgn_x[i] * half * box_cfg[RegXy]
                                                 + sgn_y[i] * half * box_cfg[RegYy]));
    end
    // edges in order top, right, bottom, left; first crossing wins
    for (int i = 0; i < 4; i++) begin
      x1  = cx[i];
      y1  = cy[i];
      x2  = cx[(i + 1) % 4];
      y2  = cy[(i + 1) % 4];
      dx1 = clamp_diff(x2, x1);
      dy1 = clamp_diff(y2, y1);
      dx2 = clamp_diff(x4, x3);
      dy2 = clamp_diff(y4, y3);
      ex  = clamp_diff(x1, x3);
      ey  = clamp_diff(y1, y3);
      den = dy2 * dx1 - dx2 * dy1;
      na  = dx2 * ey - dy2 * ex;
      nb  = dx1 * ey - dy1 * ex;
      // parallel edge never counts
      if (den == 0) continue;
      if (!in_span(na, den) || !in_span(nb, den)) continue;
      ua = edge_param(absl(na), absl(den));
      res.hit      = 1'b1;
      res.hit_edge = 2'(i);
      res.cross_x  = 32'(clamp32(x1 + drop_frac(ua * dx1)));
      res.cross_y  = 32'(clamp32(y1 + drop_frac(ua * dy1)));
      break;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    // indexes past the last register are dropped by the block
    if (idx < NumRegs) box_cfg[idx] = longint'($signed(val));
  endtask

  task automatic set_box(logic [31:0] xx, logic [31:0] xy, logic [31:0] yx,
                         logic [31:0] yy, logic [31:0] tx, logic [31:0] ty);
    write_reg(RegXx, xx);
    write_reg(RegXy, xy);
    write_reg(RegYx, yx);
    write_reg(RegYy, yy);
    write_reg(RegTx, tx);
    write_reg(RegTy, ty);
  endtask

  // one word offered until taken; expectation queued on acceptance
  task automatic send_word(bsi_in_t w);
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
    crossing_q.push_back(predict_crossing(w));
  endtask

  // random sender gap, skipped in the quiet part
  task automatic maybe_gap();
    int n;
    if (quiet || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 16);
    repeat (n) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_seg(int ox, int oy, int sx, int sy, int ex, int ey);
    bsi_in_t w;
    w.offset_x = ox;
    w.offset_y = oy;
    w.start_x  = sx;
    w.start_y  = sy;
    w.end_x    = ex;
    w.end_y    = ey;
    send_word(w);
    maybe_gap();
  endtask

  // wait for all crossings, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (crossing_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int pick(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // segment near the box with random content, some full-range noise
  task automatic send_random(int span, int cxo, int cyo);
    bsi_in_t w;
    if ($urandom_range(0, 9) < 2) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      w.offset_x = cxo + pick(span);
      w.offset_y = cyo + pick(span);
      w.start_x  = pick(span);
      w.start_y  = pick(span);
      w.end_x    = pick(span);
      w.end_y    = pick(span);
      // now and then a horizontal or vertical segment
      if ($urandom_range(0, 7) == 0) w.end_y = w.start_y;
      if ($urandom_range(0, 7) == 0) w.end_x = w.start_x;
    end
    send_word(w);
    maybe_gap();
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed();
    // identity box after reset: half a unit is 32768
    send_seg(0, 0, 0, -One, 0, One);                  // vertical, top first
    send_seg(0, 0, -One, 0, One, 0);                  // horizontal, right first
    send_seg(0, 0, 0, 0, 0, One);                     // from center out the top
    send_seg(0, 0, 0, 0, 0, -One);                    // out the bottom
    send_seg(0, 0, 0, 0, -One, 0);                    // out the left
    send_seg(0, 0, -One, 32768, One, 32768);          // along the top edge
    send_seg(0, 0, -One, -One, One, One);             // through two corners
    send_seg(0, 0, 32768, 32768, One, One);           // touching a corner
    send_seg(0, 0, 0, 0, 100, 100);                   // inside, miss
    send_seg(5 * One, 5 * One, 0, 0, One, One);       // far away, miss
    send_seg(0, 0, 0, 0, 0, 0);                       // point segment
    send_seg(0, 0, 0, 32768, 0, 32768);               // point on an edge
    send_seg(SMax, SMax, SMax, SMax, SMax, SMax);     // saturating sums
    send_seg(SMin, SMin, SMin, SMin, SMin, SMin);
    send_seg(0, 0, SMin, SMin, SMax, SMax);           // full diagonal
    send_seg(0, 0, SMax, 0, SMin, 0);
    send_seg(SMax, SMin, SMin, SMax, 0, 0);
    send_seg(-1, -1, -1, -1, -1, -1);
    send_seg(0, 0, 0, SMin, 0, SMax);
    drain();
    // ignored register indexes must leave the box alone
    write_reg(RegBad6, 32'h1234_5678);
    write_reg(RegBad7, SMin);
    send_seg(0, 0, 0, -One, 0, One);
    drain();
  endtask

  task automatic test_box_settings();
    // rotated quarter turn and moved
    set_box(0, One, -One, 0, 3 * One, -2 * One);
    for (int i = 0; i < 120; i++) send_random(2 * One, 3 * One, -2 * One);
    drain();
    // degenerate box: all corners on one point, parallel everywhere
    set_box(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 40; i++) send_random(One, 0, 0);
    drain();
    // extreme matrix and translation
    set_box(SMax, SMin, SMax, SMin, SMax, SMin);
    for (int i = 0; i < 60; i++) send_random(32'h4000_0000, 0, 0);
    drain();
    set_box(SMin, SMax, SMin, SMax, SMin, SMax);
    for (int i = 0; i < 60; i++) send_random(32'h4000_0000, 0, 0);
    drain();
    // sheared box
    set_box(2 * One, One / 2, -One / 4, 3 * One, -One, One);
    for (int i = 0; i < 150; i++) send_random(3 * One, -One, One);
    drain();
  endtask

  task automatic test_random_boxes();
    int s, tx, ty;
    for (int p = 0; p < 4; p++) begin
      s  = $urandom_range(One / 4, 8 * One);
      tx = pick(16 * One);
      ty = pick(16 * One);
      set_box(pick(s), pick(s), pick(s), pick(s), tx, ty);
      for (int i = 0; i < 120; i++) send_random(2 * s, tx, ty);
      drain();
    end
  endtask

  task automatic test_back_pressure();
    set_box(One, 0, 0, One, 0, 0);
    // receiver holds off while the sender keeps offering words
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random(2 * One, 0, 0);
    // sender pauses until every crossing has come
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (crossing_q.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 60; i++) send_random(2 * One, 0, 0);
    drain();
  endtask

  task automatic test_quiet_stream();
    quiet = 1'b1;
    set_box(3 * One / 2, One / 8, -One / 8, One, One / 2, -One / 2);
    for (int i = 0; i < 200; i++) send_random(2 * One, One / 2, -One / 2);
    drain();
  endtask

  // ---------------------------------------------------------------------
  // output stall bursts and the long hold-off
  // ---------------------------------------------------------------------
  initial begin
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 2) == 0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string fld, longint got, longint want);
    errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, fld, got, want);
  endtask

  always @(posedge clk_i) begin
    bsi_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (crossing_q.size() == 0) begin
        errors++;
        $display("unexpected word at %0t", $realtime);
      end else begin
        want = crossing_q.pop_front();
        if (out_data.hit !== want.hit) report_mismatch("hit", out_data.hit, want.hit);
        if (out_data.hit_edge !== want.hit_edge)
          report_mismatch("hit_edge", out_data.hit_edge, want.hit_edge);
        if (out_data.cross_x !== want.cross_x)
          report_mismatch("cross_x", out_data.cross_x, want.cross_x);
        if (out_data.cross_y !== want.cross_y)
          report_mismatch("cross_y", out_data.cross_y, want.cross_y);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("box_segment_intersection test failed");
      $finish;
    end
  end

  initial begin
    box_cfg = '{64'sd65536, 0, 0, 64'sd65536, 0, 0};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_box_settings();
    test_random_boxes();
    test_back_pressure();
    test_quiet_stream();
    // leftovers count as failures too
    if (errors == 0 && crossing_q.size() == 0) begin
      $display("box_segment_intersection test passed");
    end else begin
      $display("box_segment_intersection test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
